// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define VADPCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vadpcm assertion failed");

// Checks that a condition never holds outside reset.
`define VADPCM_NEVER(lbl, cond) \
  `VADPCM_ASSERT(lbl, !(cond))

`endif

// ----- rtl/vadpcm_pkg.sv -----
package vadpcm_pkg;

  localparam int HALF_LEN = 8;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_STREAM  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam int FRAC_BITS = 11;
  localparam logic signed [20:0] SAMPLE_MAX = 21'sd32767;
  localparam logic signed [20:0] SAMPLE_MIN = -21'sd32767;

  typedef struct packed {
    logic       coef_wr;
    logic       header;
    logic       restart;
    logic       res_wr;
    logic       acc_init;
    logic       issue;
    logic       finish;
    logic       out_last;
    logic       out_fend;
    logic       hist_copy;
    logic [2:0] row;
    logic [3:0] step;
  } vadpcm_cmd_t;

  typedef struct packed {
    logic [3:0] order;
    logic       pipe_busy;
    logic       out_busy;
  } vadpcm_status_t;

endpackage

// ----- rtl/vector_adpcm_decoder.sv -----
// Vector ADPCM decoder. Items are coefficient loads, stream bytes and restarts; a 9-byte
// frame (header plus eight data bytes) yields sixteen samples, two per data byte. Loads,
// restarts and headers are handled in the idle state. A data byte whose sample pair starts
// at row r of its half runs order + r steps for its first sample and one more for its
// second, on the single shared multiply-accumulate unit that does one coefficient read and
// product per cycle; each sample then drains, and a stalled output adds its wait. The input
// is taken again while the second sample of a pair still waits in the output register.
`include "assert_macros.svh"

module vector_adpcm_decoder #(
  parameter int MAX_ORDER      = 8,
  parameter int MAX_PREDICTORS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         pred_index_i,
  input  logic [2:0]         tap_index_i,
  input  logic [2:0]         row_index_i,
  input  logic signed [15:0] coef_value_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               last_o,
  output logic               frame_end_o
);
  import vadpcm_pkg::*;

  vadpcm_cmd_t    cmd;
  vadpcm_status_t status;

  vadpcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vadpcm_dp #(
    .MAX_ORDER      (MAX_ORDER),
    .MAX_PREDICTORS (MAX_PREDICTORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pred_index_i (pred_index_i),
    .tap_index_i  (tap_index_i),
    .row_index_i  (row_index_i),
    .coef_value_i (coef_value_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_o     (sample_o),
    .last_o       (last_o),
    .frame_end_o  (frame_end_o)
  );

  `VADPCM_NEVER(a_accept_pipe_idle, in_valid_i && !in_stall_o && status.pipe_busy)
  `VADPCM_ASSERT(a_fend_on_last, out_valid_o && frame_end_o |-> last_o)
  `VADPCM_NEVER(a_sample_clamped, out_valid_o && (sample_o == -16'sd32768))
  `VADPCM_NEVER(a_finish_drained, cmd.finish && status.pipe_busy)

endmodule

// ----- rtl/vadpcm_ctrl.sv -----
module vadpcm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  vadpcm_pkg::vadpcm_status_t  status_i,
  output vadpcm_pkg::vadpcm_cmd_t     cmd_o
);
  import vadpcm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_INIT, ST_MAC, ST_DRAIN} state_e;

  state_e     state_q, state_d;
  logic [3:0] bpos_q, bpos_d;
  logic [2:0] row_q, row_d;
  logic [3:0] step_q, step_d;
  logic       second_q, second_d;
  logic       half_q, half_d;
  logic       frame_q, frame_d;
  logic       accept;
  logic [2:0] b;
  logic       step_last;
  logic       out_ready;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign b          = 3'(bpos_q - 4'd1);
  assign step_last  = (5'(step_q) == 5'(status_i.order) + 5'(row_q) - 5'd1);
  assign out_ready  = !status_i.pipe_busy && !status_i.out_busy;

  always_comb begin
    cmd_o      = '0;
    cmd_o.row  = row_q;
    cmd_o.step = step_q;
    state_d    = state_q;
    bpos_d     = bpos_q;
    row_d      = row_q;
    step_d     = step_q;
    second_d   = second_q;
    half_d     = half_q;
    frame_d    = frame_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_LOAD:    cmd_o.coef_wr = 1'b1;
            KIND_RESTART: begin
              cmd_o.restart = 1'b1;
              bpos_d        = '0;
            end
            KIND_STREAM: begin
              if (bpos_q == '0) begin
                cmd_o.header = 1'b1;
                bpos_d       = 4'd1;
              end else begin
                cmd_o.res_wr = 1'b1;
                cmd_o.row    = {b[1:0], 1'b0};
                row_d        = {b[1:0], 1'b0};
                half_d       = (b[1:0] == 2'd3);
                frame_d      = (b == 3'd7);
                second_d     = 1'b0;
                bpos_d       = (b == 3'd7) ? 4'd0 : bpos_q + 4'd1;
                state_d      = ST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.acc_init = 1'b1;
        step_d         = '0;
        state_d        = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        step_d      = step_q + 4'd1;
        if (step_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_ready) begin
          cmd_o.finish    = 1'b1;
          cmd_o.out_last  = second_q;
          cmd_o.out_fend  = second_q && frame_q;
          cmd_o.hist_copy = second_q && half_q;
          if (second_q) begin
            state_d = ST_IDLE;
          end else begin
            second_d = 1'b1;
            row_d    = row_q + 3'd1;
            state_d  = ST_INIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bpos_q   <= '0;
      row_q    <= '0;
      step_q   <= '0;
      second_q <= 1'b0;
      half_q   <= 1'b0;
      frame_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      bpos_q   <= bpos_d;
      row_q    <= row_d;
      step_q   <= step_d;
      second_q <= second_d;
      half_q   <= half_d;
      frame_q  <= frame_d;
    end
  end

endmodule

// ----- rtl/vadpcm_dp.sv -----
module vadpcm_dp #(
  parameter int MAX_ORDER      = 8,
  parameter int MAX_PREDICTORS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vadpcm_pkg::vadpcm_cmd_t     cmd_i,
  output vadpcm_pkg::vadpcm_status_t  status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [4:0]                  cfg_wdata_i,
  input  logic [3:0]                  pred_index_i,
  input  logic [2:0]                  tap_index_i,
  input  logic [2:0]                  row_index_i,
  input  logic signed [15:0]          coef_value_i,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          sample_o,
  output logic                        last_o,
  output logic                        frame_end_o
);
  import vadpcm_pkg::*;

  localparam int NUM_COEF = MAX_PREDICTORS * MAX_ORDER * HALF_LEN;
  localparam int AW       = $clog2(NUM_COEF);

  logic signed [15:0] coef_mem [NUM_COEF];
  logic [31:0]        hist_q   [HALF_LEN];
  logic [31:0]        half_q   [HALF_LEN];
  logic signed [19:0] res_q    [HALF_LEN];

  logic [3:0] order_cfg_q;
  logic [4:0] count_cfg_q;
  logic [3:0] scale_q;
  logic [3:0] pred_q;
  logic [3:0] order;

  logic [AW-1:0]      wr_addr, rd_addr;
  logic               wr_ok;
  logic [3:0]         tap;
  logic [2:0]         rrow;
  logic [2:0]         hidx;
  logic [2:0]         kidx;
  logic [31:0]        opnd;
  logic [3:0]         hdr_pred;

  logic signed [15:0] coef_q;
  logic [31:0]        opnd_q;
  logic               rd_v_q;
  logic [31:0]        prod_q;
  logic               prod_v_q;
  logic [31:0]        acc_q;
  logic signed [47:0] prod_full;

  logic signed [20:0] floor_v;
  logic signed [15:0] clamped;
  logic signed [19:0] res_hi, res_lo;

  logic               out_v_q;
  logic signed [15:0] sample_q;
  logic               last_q, fend_q;

  always_comb begin
    if (order_cfg_q == 4'd0) begin
      order = 4'd1;
    end else if (int'(order_cfg_q) > MAX_ORDER) begin
      order = 4'(MAX_ORDER);
    end else begin
      order = order_cfg_q;
    end
  end

  assign status_o.order     = order;
  assign status_o.pipe_busy = rd_v_q || prod_v_q;
  assign status_o.out_busy  = out_v_q && out_stall_i;

  assign wr_ok   = (int'(pred_index_i) < MAX_PREDICTORS) && (int'(tap_index_i) < MAX_ORDER);
  assign wr_addr = AW'((int'(pred_index_i) * MAX_ORDER + int'(tap_index_i)) * HALF_LEN
                       + int'(row_index_i));

  // Steps below the order walk the history taps; later steps walk earlier residuals
  // of this half through the last tap's coefficients.
  always_comb begin
    hidx = 3'(5'(HALF_LEN) - 5'(order) + 5'(cmd_i.step));
    kidx = 3'(cmd_i.step - order);
    if (cmd_i.step < order) begin
      tap  = cmd_i.step;
      rrow = cmd_i.row;
      opnd = hist_q[hidx];
    end else begin
      tap  = order - 4'd1;
      rrow = cmd_i.row - kidx - 3'd1;
      opnd = 32'(res_q[kidx]);
    end
  end

  assign rd_addr = AW'((int'(pred_q) * MAX_ORDER + int'(tap)) * HALF_LEN + int'(rrow));

  assign hdr_pred = ((5'(data_byte_i[3:0]) >= count_cfg_q)
                     || (int'(data_byte_i[3:0]) >= MAX_PREDICTORS)) ? 4'd0 : data_byte_i[3:0];

  assign res_hi = 20'(signed'(data_byte_i[7:4])) <<< scale_q;
  assign res_lo = 20'(signed'(data_byte_i[3:0])) <<< scale_q;

  assign prod_full = coef_q * signed'(opnd_q);
  assign floor_v   = 21'(signed'(acc_q) >>> FRAC_BITS);

  always_comb begin
    if (floor_v > SAMPLE_MAX) begin
      clamped = 16'(SAMPLE_MAX);
    end else if (floor_v < SAMPLE_MIN) begin
      clamped = 16'(SAMPLE_MIN);
    end else begin
      clamped = 16'(floor_v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && wr_ok) begin
      coef_mem[wr_addr] <= coef_value_i;
    end
    coef_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd;
    prod_q <= prod_full[31:0];
    if (cmd_i.res_wr) begin
      res_q[cmd_i.row]        <= res_hi;
      res_q[cmd_i.row + 3'd1] <= res_lo;
    end
    if (cmd_i.acc_init) begin
      acc_q <= 32'(res_q[cmd_i.row]) << FRAC_BITS;
    end else if (prod_v_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.finish) begin
      half_q[cmd_i.row] <= 32'(floor_v);
      sample_q          <= clamped;
      last_q            <= cmd_i.out_last;
      fend_q            <= cmd_i.out_fend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_cfg_q <= 4'd2;
      count_cfg_q <= 5'd1;
      scale_q     <= '0;
      pred_q      <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      for (int k = 0; k < HALF_LEN; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_ORDER: order_cfg_q <= cfg_wdata_i[3:0];
          CFG_COUNT: count_cfg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.header) begin
        scale_q <= data_byte_i[7:4];
        pred_q  <= hdr_pred;
      end
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
      if (cmd_i.restart) begin
        for (int k = 0; k < HALF_LEN; k++) begin
          hist_q[k] <= '0;
        end
      end else if (cmd_i.hist_copy) begin
        // The last sample of the half lands in history in the same cycle.
        for (int k = 0; k < HALF_LEN; k++) begin
          hist_q[k] <= (3'(k) == cmd_i.row) ? 32'(floor_v) : half_q[k];
        end
      end
      if (cmd_i.finish) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;
  assign frame_end_o = fend_q;

endmodule
